/* design/cpr_pkg.sv */
// cpr_pkg: shared constants, point and result types for the collinear point remover
// no dependencies; imported by every other design file
package cpr_pkg;

    localparam int FIELD_BITS = 32;
    localparam int COORD_BITS = 32;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [PROD_BITS-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
        logic   too_short;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

/* design/cpr_ifs.sv */
// cpr_ifs: valid/ready stream interfaces for input points and result points
// depends on cpr_pkg for the field widths
interface cpr_point_if;
    import cpr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
    logic                  final_point;

    modport source (output valid, output point_x, output point_y, output final_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input final_point,
                    output ready);
endinterface

interface cpr_result_if;
    import cpr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] out_x;
    logic [FIELD_BITS-1:0] out_y;
    logic                  out_last;
    logic                  too_short;

    modport source (output valid, output out_x, output out_y, output out_last,
                    output too_short, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_last,
                    input too_short, output ready);
endinterface

/* design/collinear_point_remover.sv */
// collinear_point_remover: top level, drops middle points of a polyline that lie on a line
// depends on cpr_pkg, cpr_ifs, cpr_core, cpr_cross and cpr_res_fifo
//
// Points enter on i_pt, one request per cycle at full rate while the queue has room, and
// are held in an input register; the exact integer cross product of anchor->pending and
// pending->next is formed in the following cycle and the kept points go into a four-entry
// result queue, which offers them on o_res. The first and last points of a line always
// come out; a line of one or two points passes unchanged with too_short set on its final
// result. A final point that follows a kept corner gives two results, which leave the
// queue one after the other; the input keeps accepting while the queue has room for two
// more results, so the sustained rate is one point per cycle when each point yields at
// most one result and the sink is ready.
module collinear_point_remover (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpr_point_if.sink    i_pt,
    cpr_result_if.source o_res
);
    import cpr_pkg::*;

    t_push push;
    logic  room;

    cpr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_room  (room),
        .o_push  (push)
    );

    cpr_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );
endmodule

/* design/cpr_cross.sv */
// cpr_cross: exact test for a zero cross product of anchor->pending and pending->next
// depends on cpr_pkg; two parallel multiplies and two wide compares
module cpr_cross (
    input  cpr_pkg::t_point i_anchor,
    input  cpr_pkg::t_point i_pend,
    input  cpr_pkg::t_point i_next,
    output logic            o_zero
);
    import cpr_pkg::*;

    t_coord ax, ay, bx, by;
    logic   nax, nay, nbx, nby;
    t_prod  m1, m2;

    always_comb begin
        nax = i_pend.x < i_anchor.x;
        nay = i_pend.y < i_anchor.y;
        nbx = i_next.x < i_pend.x;
        nby = i_next.y < i_pend.y;
        ax  = nax ? i_anchor.x - i_pend.x : i_pend.x - i_anchor.x;
        ay  = nay ? i_anchor.y - i_pend.y : i_pend.y - i_anchor.y;
        bx  = nbx ? i_pend.x - i_next.x : i_next.x - i_pend.x;
        by  = nby ? i_pend.y - i_next.y : i_next.y - i_pend.y;
        m1  = PROD_BITS'(ax) * PROD_BITS'(by);
        m2  = PROD_BITS'(ay) * PROD_BITS'(bx);
        if (m1 != m2) begin
            o_zero = 1'b0;
        end else if (m1 == '0) begin
            o_zero = 1'b1;
        end else begin
            o_zero = ((nax != nby) == (nay != nbx));
        end
    end
endmodule

/* design/cpr_core.sv */
// cpr_core: input register, anchor/pending state and the keep/drop decision
// depends on cpr_pkg and cpr_cross; hands up to two results per point to the queue
module cpr_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpr_point_if.sink     i_pt,
    input  logic          i_room,
    output cpr_pkg::t_push o_push
);
    import cpr_pkg::*;

    typedef enum logic [1:0] {
        SEEN_START,
        SEEN_ANCHOR,
        SEEN_PENDING
    } t_seen;

    t_seen  r_seen, n_seen;
    logic   r_in_valid;
    t_point r_in_pt;
    logic   r_in_fin;
    t_point r_anchor, n_anchor;
    t_point r_pend, n_pend;
    logic   fire;
    logic   zero;

    assign fire       = r_in_valid && i_room;
    assign i_pt.ready = !r_in_valid || fire;

    cpr_cross u_cross (
        .i_anchor (r_anchor),
        .i_pend   (r_pend),
        .i_next   (r_in_pt),
        .o_zero   (zero)
    );

    always_comb begin
        n_seen   = r_seen;
        n_anchor = r_anchor;
        n_pend   = r_pend;
        o_push   = '0;
        o_push.res0 = '{x: r_in_pt.x, y: r_in_pt.y, last: r_in_fin, too_short: r_in_fin};
        o_push.res1 = '{x: r_in_pt.x, y: r_in_pt.y, last: 1'b1, too_short: 1'b0};
        if (fire) begin
            case (r_seen)
                SEEN_START: begin
                    o_push.push0 = 1'b1;
                    if (!r_in_fin) begin
                        n_anchor = r_in_pt;
                        n_seen   = SEEN_ANCHOR;
                    end
                end
                SEEN_ANCHOR: begin
                    if (r_in_fin) begin
                        o_push.push0 = 1'b1;
                        n_seen       = SEEN_START;
                    end else begin
                        n_pend = r_in_pt;
                        n_seen = SEEN_PENDING;
                    end
                end
                default: begin
                    n_pend = r_in_pt;
                    if (!zero) begin
                        // pending point is a real corner: keep it, it becomes the anchor
                        o_push.push0 = 1'b1;
                        o_push.res0  = '{x: r_pend.x, y: r_pend.y, last: 1'b0,
                                         too_short: 1'b0};
                        o_push.push1 = r_in_fin;
                        n_anchor     = r_pend;
                    end else if (r_in_fin) begin
                        o_push.push0 = 1'b1;
                        o_push.res0  = o_push.res1;
                    end
                    n_seen = r_in_fin ? SEEN_START : SEEN_PENDING;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_seen     <= SEEN_START;
            r_anchor   <= '0;
            r_pend     <= '0;
        end else begin
            if (i_pt.valid && i_pt.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_seen   <= n_seen;
            r_anchor <= n_anchor;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.valid && i_pt.ready) begin
            r_in_pt.x <= COORD_BITS'(i_pt.point_x);
            r_in_pt.y <= COORD_BITS'(i_pt.point_y);
            r_in_fin  <= i_pt.final_point;
        end
    end
endmodule

/* design/cpr_res_fifo.sv */
// cpr_res_fifo: small result queue taking up to two results a cycle, giving one
// depends on cpr_pkg and cpr_ifs; reports room for two more results to the core
module cpr_res_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpr_pkg::t_push i_push,
    output logic           o_room,
    cpr_result_if.source   o_res
);
    import cpr_pkg::*;

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count, n_count;
    logic [RES_PTR_W-1:0]   wr_ptr1;
    logic                   pop;
    t_result                head;

    assign head          = r_mem[r_rd_ptr];
    assign o_res.valid   = (r_count != '0);
    assign o_res.out_x   = FIELD_BITS'(head.x);
    assign o_res.out_y   = FIELD_BITS'(head.y);
    assign o_res.out_last  = head.last;
    assign o_res.too_short = head.too_short;
    assign pop           = o_res.valid && o_res.ready;
    assign o_room        = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign wr_ptr1       = r_wr_ptr + RES_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(i_push.push0) + RES_PTR_W'(i_push.push1);
        n_count  = r_count + RES_CNT_W'(i_push.push0) + RES_CNT_W'(i_push.push1)
                   - RES_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end
endmodule
